### sv/piecewise_linear_schedule_lookup_defines.svh
// Assertion macros for the piecewise-linear schedule lookup.
// Included by the RTL files that carry concurrent assertions; expects clk and arst_n in scope.
`ifndef PIECEWISE_LINEAR_SCHEDULE_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_SCHEDULE_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PLSL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/plsl_pkg.sv
// Shared constants and codes for the piecewise-linear schedule lookup.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package plsl_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int BUDGET_BITS = 20;
	localparam int TIME_W      = 32;
	localparam int ADDR_W      = $clog2(MAX_ROWS);
	localparam int CNT_W       = $clog2(MAX_ROWS + 1);
	localparam int ROW_W       = TIME_W + BUDGET_BITS;
	localparam int PROD_W      = TIME_W + BUDGET_BITS;
	localparam int DIV_CNT_W   = $clog2(PROD_W + 1);

	// Port field widths.
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int FIELD_B_W   = 20;
	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 24;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2,
		STATUS_RSVD  = 2'd3
	} status_t;

	localparam logic [PADDR_W-3:0] REG_INTERP_MODE = 1'b0;

endpackage

### sv/piecewise_linear_schedule_lookup.sv
// Piecewise-linear schedule lookup: breakpoint table in a synchronous RAM, sequential query FSM.
// Depends on plsl_pkg and piecewise_linear_schedule_lookup_defines.svh.
`timescale 1ns / 1ps

// One beat in, one beat out. Clear, append, unused kinds and queries on an empty
// table go straight from idle to the output state. A query reads row 0, then the
// last row, then scans the rows from row 1 one RAM read per cycle (single read
// port, registered read data), reading at most row_count - 1 rows in the scan.
// Linear mode then adds a multiply step, a restoring divide over the 52-bit
// product (one quotient bit a cycle) and a rounding step. A new beat is taken
// while the previous result waits in the output register. No clearing pass is
// needed after reset.
module piecewise_linear_schedule_lookup (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input stream. tdata: time_ms [31:0], budget_mb [51:32], zero [55:52].
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [plsl_pkg::S_TDATA_W-1:0]        s_tdata,
	// tuser: kind [1:0].
	input  logic [plsl_pkg::KIND_W-1:0]           s_tuser,
	// Result stream. tdata: budget_out [19:0], zero [23:20].
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [plsl_pkg::M_TDATA_W-1:0]        m_tdata,
	// tuser: status [1:0].
	output logic [plsl_pkg::STATUS_W-1:0]         m_tuser,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [plsl_pkg::PADDR_W-1:0]          paddr,
	input  logic [plsl_pkg::PDATA_W-1:0]          pwdata,
	output logic [plsl_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);
	import plsl_pkg::*;
	`include "piecewise_linear_schedule_lookup_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD0, ST_RDN, ST_SCAN, ST_MUL, ST_DIV, ST_ROUND, ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        row_count_q;
	logic                    mode_q;

	logic [TIME_W-1:0]       t_q;
	logic [ADDR_W-1:0]       idx_q;
	logic [TIME_W-1:0]       prev_t_q;
	logic [BUDGET_BITS-1:0]  prev_b_q;
	logic [BUDGET_BITS-1:0]  res_q;
	status_t                 stat_q;
	logic [TIME_W-1:0]       x_q;
	logic [TIME_W-1:0]       dt_q;
	logic [BUDGET_BITS-1:0]  db_q;
	logic                    down_q;
	logic [PROD_W-1:0]       prod_q;
	logic [TIME_W:0]         rem_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic                    m_tvalid_q;
	logic [BUDGET_BITS-1:0]  m_budget_q;
	status_t                 m_status_q;

	logic [ROW_W-1:0]        rows_mem [MAX_ROWS];
	logic [ROW_W-1:0]        rd_data_q;
	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    wr_en;

	kind_t                   kind_in;
	logic [TIME_W-1:0]       t_in;
	logic [BUDGET_BITS-1:0]  b_in;
	logic                    s_accept;
	logic                    full;
	logic [TIME_W-1:0]       rd_t;
	logic [BUDGET_BITS-1:0]  rd_b;
	logic [CNT_W-1:0]        last_row;
	logic                    scan_more;
	logic                    out_free;

	logic [TIME_W:0]         rem_sh;
	logic                    div_ge;
	logic [TIME_W-1:0]       rem_lo;
	logic [TIME_W-1:0]       half_gap;
	logic                    round_up;
	logic [BUDGET_BITS-1:0]  q_b;
	logic [BUDGET_BITS-1:0]  lerp_res;

	assign kind_in  = kind_t'(s_tuser);
	assign t_in     = s_tdata[TIME_W-1:0];
	assign b_in     = BUDGET_BITS'(s_tdata[TIME_W+FIELD_B_W-1:TIME_W]);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign full     = (row_count_q == CNT_W'(MAX_ROWS));
	assign rd_t     = rd_data_q[TIME_W-1:0];
	assign rd_b     = rd_data_q[ROW_W-1:TIME_W];
	assign last_row = row_count_q - CNT_W'(1);
	assign out_free = !m_tvalid_q || m_tready;

	// Keep scanning while the row just read is not past the query time and is not the last row.
	assign scan_more = (CNT_W'(idx_q) < last_row) && (rd_t <= t_q);

	assign wr_en = s_accept && (kind_in == KIND_APPEND) && !full;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && kind_in == KIND_QUERY && row_count_q != '0) begin
					rd_en = 1'b1;
				end
			end
			ST_RD0: begin
				if (!(t_q <= rd_t)) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(last_row);
				end
			end
			ST_RDN: begin
				if (!(t_q >= rd_t)) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(1);
				end
			end
			ST_SCAN: begin
				if (scan_more) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + ADDR_W'(1);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Breakpoint RAM: one write port for appends, one registered read port for the query FSM.
	// Appends and reads never overlap, since only one beat is in flight at a time.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_mem[ADDR_W'(row_count_q)] <= {b_in, t_in};
		end
		if (rd_en) begin
			rd_data_q <= rows_mem[rd_addr];
		end
	end

	// Restoring divide step: one quotient bit shifts into prod_q as the dividend shifts out.
	assign rem_sh = {rem_q[TIME_W-1:0], prod_q[PROD_W-1]};
	assign div_ge = (rem_sh >= {1'b0, dt_q});

	// Round half up on the real value; for a falling segment that means ties go towards lo.
	assign rem_lo   = rem_q[TIME_W-1:0];
	assign half_gap = dt_q - rem_lo;
	assign round_up = down_q ? (rem_lo > half_gap) : (rem_lo >= half_gap);
	assign q_b      = BUDGET_BITS'(prod_q) + BUDGET_BITS'(round_up);
	assign lerp_res = down_q ? (prev_b_q - q_b) : (prev_b_q + q_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_count_q <= '0;
			m_tvalid_q  <= 1'b0;
			m_budget_q  <= '0;
			m_status_q  <= STATUS_OK;
			t_q         <= '0;
			idx_q       <= '0;
			prev_t_q    <= '0;
			prev_b_q    <= '0;
			res_q       <= '0;
			stat_q      <= STATUS_OK;
			x_q         <= '0;
			dt_q        <= '0;
			db_q        <= '0;
			down_q      <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
		end else begin
			// In ST_DONE the output register is refilled below whenever it drains.
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						t_q   <= t_in;
						res_q <= '0;
						unique case (kind_in)
							KIND_CLEAR: begin
								row_count_q <= '0;
								stat_q      <= STATUS_OK;
								state_q     <= ST_DONE;
							end
							KIND_APPEND: begin
								state_q <= ST_DONE;
								if (full) begin
									stat_q <= STATUS_FULL;
								end else begin
									stat_q      <= STATUS_OK;
									row_count_q <= row_count_q + CNT_W'(1);
								end
							end
							KIND_QUERY: begin
								if (row_count_q == '0) begin
									stat_q  <= STATUS_EMPTY;
									state_q <= ST_DONE;
								end else begin
									stat_q  <= STATUS_OK;
									state_q <= ST_RD0;
								end
							end
							KIND_UNUSED: begin
								stat_q  <= STATUS_OK;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RD0: begin
					prev_t_q <= rd_t;
					prev_b_q <= rd_b;
					if (t_q <= rd_t) begin
						res_q   <= rd_b;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RDN;
					end
				end
				ST_RDN: begin
					if (t_q >= rd_t) begin
						res_q   <= rd_b;
						state_q <= ST_DONE;
					end else begin
						idx_q   <= ADDR_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						prev_t_q <= rd_t;
						prev_b_q <= rd_b;
						idx_q    <= idx_q + ADDR_W'(1);
					end else if (!mode_q) begin
						res_q   <= prev_b_q;
						state_q <= ST_DONE;
					end else begin
						x_q     <= t_q - prev_t_q;
						dt_q    <= rd_t - prev_t_q;
						down_q  <= (rd_b < prev_b_q);
						db_q    <= (rd_b < prev_b_q) ? (prev_b_q - rd_b) : (rd_b - prev_b_q);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q    <= db_q * x_q;
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					rem_q     <= div_ge ? (rem_sh - {1'b0, dt_q}) : rem_sh;
					prod_q    <= {prod_q[PROD_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					res_q   <= lerp_res;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_budget_q <= res_q;
						m_status_q <= stat_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1:2] == REG_INTERP_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_INTERP_MODE) ? PDATA_W'(mode_q) : '0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(FIELD_B_W'(m_budget_q));
	assign m_tuser  = m_status_q;

	`PLSL_ASSERT_IMPL(a_count_bound, 1'b1, row_count_q <= CNT_W'(MAX_ROWS), "row count overflow")
	`PLSL_ASSERT_NEXT(a_append_count, wr_en, row_count_q == $past(row_count_q) + CNT_W'(1), "append lost")
	`PLSL_ASSERT_IMPL(a_div_nonzero, state_q == ST_DIV, dt_q != '0, "zero divisor in divide")
	`PLSL_ASSERT_IMPL(a_scan_in_table, state_q == ST_SCAN, CNT_W'(idx_q) < row_count_q, "scan past last row")

endmodule

### tb/tb_piecewise_linear_schedule_lookup.sv
// Self-checking testbench for the piecewise-linear schedule lookup: a queue-fed stream driver,
// a result monitor with random back-pressure and a bit-exact table predictor.
// Depends on plsl_pkg and the piecewise_linear_schedule_lookup top level.
`timescale 1ns / 1ps

module tb_piecewise_linear_schedule_lookup;
	import plsl_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int TAIL_CYCLES = 128;
	localparam int ITEM_TARGET = 1950;

	typedef struct packed {
		kind_t             kind;
		logic [TIME_W-1:0] time_ms;
		logic [19:0]       budget_mb;
	} sched_beat_t;

	typedef struct packed {
		logic [19:0] budget_out;
		status_t     status;
	} lookup_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	piecewise_linear_schedule_lookup DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: a private copy of the breakpoint table and the mode register.
	logic [TIME_W-1:0] tab_time [MAX_ROWS];
	logic [19:0]       tab_budget [MAX_ROWS];
	int                tab_rows = 0;
	logic              interp_linear = 1'b0;

	sched_beat_t       beats_pending [$];
	lookup_result_t    budget_expected [$];
	logic [TIME_W-1:0] plan_times [$];
	int                items_queued = 0;
	int                idle_pct = 20;
	int                fault_count = 0;
	int                cycle_count = 0;

	function automatic logic [19:0] interp_round(logic [19:0] lo_b, logic [19:0] hi_b,
			logic [TIME_W-1:0] x, logic [TIME_W-1:0] dt);
		logic [63:0] lo64, hi64, x64, dt64, p, q, r;
		lo64 = lo_b;
		hi64 = hi_b;
		x64  = x;
		dt64 = dt;
		if (hi64 >= lo64) begin
			p = (hi64 - lo64) * x64;
			q = p / dt64;
			r = p % dt64;
			if (r >= dt64 - r)
				q = q + 1;
			return 20'(lo64 + q);
		end
		// Falling segment: an exact half rounds towards the higher value, so q is not bumped.
		p = (lo64 - hi64) * x64;
		q = p / dt64;
		r = p % dt64;
		if (r > dt64 - r)
			q = q + 1;
		return 20'(lo64 - q);
	endfunction

	function automatic logic [19:0] lookup_budget(logic [TIME_W-1:0] t);
		int i;
		if (t <= tab_time[0])
			return tab_budget[0];
		if (t >= tab_time[tab_rows-1])
			return tab_budget[tab_rows-1];
		i = 1;
		while (i < tab_rows - 1 && tab_time[i] <= t)
			i++;
		if (!interp_linear)
			return tab_budget[i-1];
		return interp_round(tab_budget[i-1], tab_budget[i], t - tab_time[i-1],
			tab_time[i] - tab_time[i-1]);
	endfunction

	function automatic lookup_result_t apply_beat(sched_beat_t bt);
		lookup_result_t res;
		res.budget_out = '0;
		res.status     = STATUS_OK;
		case (bt.kind)
			KIND_CLEAR: tab_rows = 0;
			KIND_APPEND: begin
				if (tab_rows >= MAX_ROWS) begin
					res.status = STATUS_FULL;
				end else begin
					tab_time[tab_rows]   = bt.time_ms;
					tab_budget[tab_rows] = bt.budget_mb;
					tab_rows++;
				end
			end
			KIND_QUERY: begin
				if (tab_rows == 0)
					res.status = STATUS_EMPTY;
				else
					res.budget_out = lookup_budget(bt.time_ms);
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic push_beat(input kind_t k, input logic [TIME_W-1:0] t, input logic [19:0] b);
		sched_beat_t bt;
		bt.kind      = k;
		bt.time_ms   = t;
		bt.budget_mb = b;
		beats_pending.push_back(bt);
		if (k != KIND_UNUSED)
			items_queued++;
		// Mirror of the table contents, used only to aim query times at the rows.
		if (k == KIND_CLEAR)
			plan_times.delete();
		else if (k == KIND_APPEND && plan_times.size() < MAX_ROWS)
			plan_times.push_back(t);
	endtask

	function automatic logic [19:0] pick_budget();
		logic [19:0] v;
		v = 20'($urandom);
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [TIME_W-1:0] next_row_time(logic [TIME_W-1:0] t);
		logic [TIME_W:0] s;
		case ($urandom_range(0, 3))
			0: s = {1'b0, t} + $urandom_range(0, 10);
			1: s = {1'b0, t} + $urandom_range(1, 1000);
			2: s = {1'b0, t} + $urandom_range(1, 1 << 20);
			default: s = {1'b0, t} + $urandom_range(1, 1 << 28);
		endcase
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] pick_query_time();
		int n, k;
		logic [TIME_W-1:0] v;
		n = plan_times.size();
		v = $urandom;
		if (n == 0)
			return v;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 7))
			0: ;
			1: v = '0;
			2: v = '1;
			3: v = plan_times[k];
			4: v = plan_times[k] + 1;
			5: v = plan_times[k] - 1;
			default: begin
				if (k + 1 < n && plan_times[k+1] > plan_times[k])
					v = $urandom_range(plan_times[k+1], plan_times[k]);
				else
					v = plan_times[k];
			end
		endcase
		return v;
	endfunction

	// Queries around the directed table: before, on and between rows, and past the end.
	task automatic push_probes();
		push_beat(KIND_QUERY, 32'd0, pick_budget());
		push_beat(KIND_QUERY, 32'd100, pick_budget());
		push_beat(KIND_QUERY, 32'd600, pick_budget());
		push_beat(KIND_QUERY, 32'd1100, pick_budget());
		push_beat(KIND_QUERY, 32'd3001, pick_budget());
		push_beat(KIND_QUERY, 32'hFFFF_FFFF, pick_budget());
	endtask

	// Sampled on the falling edge, so that everything driven at the rising edge has settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_pending.size() != 0 || s_tvalid || budget_expected.size() != 0);
	endtask

	task automatic apb_write(input logic [PADDR_W-3:0] idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_INTERP_MODE)
			interp_linear = data[0];
	endtask

	// Stream driver.
	sched_beat_t beat_on_bus;
	int          send_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				budget_expected.push_back(apply_beat(beat_on_bus));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (beats_pending.size() > 0) begin
					beat_on_bus = beats_pending.pop_front();
					s_tdata  <= {4'b0000, beat_on_bus.budget_mb, beat_on_bus.time_ms};
					s_tuser  <= beat_on_bus.kind;
					s_tvalid <= 1'b1;
					if ($urandom_range(0, 99) < idle_pct)
						send_gap = $urandom_range(1, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	int recv_stall = 0;

	always @(posedge clk) begin
		lookup_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (budget_expected.size() == 0) begin
					$error("unexpected result beat: budget_out %h status %0d",
						m_tdata[19:0], m_tuser);
					fault_count++;
				end else begin
					want = budget_expected.pop_front();
					if (m_tdata[19:0] !== want.budget_out) begin
						$error("budget_out: expected %h, actual %h", want.budget_out,
							m_tdata[19:0]);
						fault_count++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tuser);
						fault_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				recv_stall = $urandom_range(0, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int ph, phase_end, nrows, nq, j;
		logic [TIME_W-1:0] t_row;
		logic [PDATA_W-1:0] wdata;
		logic broken;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_CLEAR;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extreme budgets, a repeated row time, step mode first.
		push_beat(KIND_QUERY, $urandom, pick_budget());
		push_beat(KIND_APPEND, 32'd100, 20'hFFFFF);
		push_beat(KIND_APPEND, 32'd1100, 20'h00000);
		push_beat(KIND_APPEND, 32'd1100, 20'd500);
		push_beat(KIND_APPEND, 32'd5000, 20'h12345);
		push_beat(KIND_APPEND, 32'hFFFF_FFF0, 20'd7);
		push_probes();
		push_beat(KIND_UNUSED, $urandom, 20'($urandom));
		wait_idle();
		// A write to the unmapped index must leave the mode alone.
		apb_write(1'b1, 32'hFFFF_FFFF);
		push_beat(KIND_QUERY, 32'd4000, pick_budget());
		wait_idle();
		apb_write(REG_INTERP_MODE, 32'hFFFF_FFFF);
		push_probes();
		push_beat(KIND_CLEAR, $urandom, 20'($urandom));
		push_beat(KIND_QUERY, $urandom, 20'($urandom));

		for (ph = 0; ph < 6; ph++) begin
			wait_idle();
			wdata = $urandom;
			case (ph)
				0: wdata[0] = 1'b1;
				1: wdata[0] = 1'b0;
				2: wdata[0] = 1'b1;
				default: ;
			endcase
			apb_write(REG_INTERP_MODE, wdata);
			case (ph)
				0: idle_pct = 25;
				1: idle_pct = 10;
				3: idle_pct = 40;
				4: idle_pct = 15;
				default: idle_pct = 0;
			endcase
			phase_end = ITEM_TARGET * (ph + 1) / 6;
			while (items_queued < phase_end) begin
				if ($urandom_range(0, 99) < 8) begin
					// Noise: any kind, any content.
					nq = $urandom_range(1, 4);
					for (j = 0; j < nq; j++)
						push_beat(kind_t'($urandom_range(0, 3)), $urandom, 20'($urandom));
				end else begin
					if ($urandom_range(0, 9) != 0)
						push_beat(KIND_CLEAR, $urandom, 20'($urandom));
					if ($urandom_range(0, 19) == 0)
						push_beat(KIND_QUERY, $urandom, 20'($urandom));
					j = $urandom_range(0, 99);
					if (j < 8)
						nrows = MAX_ROWS + $urandom_range(0, 3);
					else if (j < 20)
						nrows = $urandom_range(9, 40);
					else
						nrows = $urandom_range(1, 8);
					broken = ($urandom_range(0, 9) == 0);
					t_row  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
					for (j = 0; j < nrows; j++) begin
						if (broken && $urandom_range(0, 3) == 0)
							push_beat(KIND_APPEND, $urandom, pick_budget());
						else
							push_beat(KIND_APPEND, t_row, pick_budget());
						t_row = next_row_time(t_row);
					end
					nq = $urandom_range(1, 10);
					for (j = 0; j < nq; j++)
						push_beat(KIND_QUERY, pick_query_time(), pick_budget());
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && budget_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/plsl_pkg.sv
sv/piecewise_linear_schedule_lookup.sv
tb/tb_piecewise_linear_schedule_lookup.sv
